// ===== hw/rtl/tdg_pkg.sv =====
// Shared types, constants and the operation table for the triangle
// displacement gradient block. No dependencies.
`default_nettype none

package tdg_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int OUT_WIDTH   = 32;
  localparam int GRAD_FRAC   = 16;
  localparam int NUM_OPS     = 27;
  localparam int STEP_W      = 5;

  localparam logic [1:0] CORNER_0 = 2'd0;
  localparam logic [1:0] CORNER_1 = 2'd1;
  localparam logic [1:0] CORNER_2 = 2'd2;
  localparam logic [1:0] LAST_IDX = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MLOAD, ST_MSTEP, ST_CHECK, ST_DLOAD,
    ST_DSTEP, ST_DRND, ST_DSAT, ST_EMIT
  } state_t;

  typedef enum logic [4:0] {
    OP_U0, OP_U1, OP_U2, OP_V0, OP_V1, OP_V2,
    OP_N0, OP_N1, OP_N2, OP_W10, OP_W11, OP_W12,
    OP_W20, OP_W21, OP_W22, OP_D20, OP_D21, OP_D22,
    OP_D30, OP_D31, OP_D32, OP_S, OP_M0, OP_M1, OP_M2
  } opnd_t;

  // one product term: acc +/-= a * b, then optionally write acc to dst
  typedef struct packed {
    opnd_t a;
    opnd_t b;
    logic  sub;
    logic  lng;
    logic  last;
    opnd_t dst;
  } op_t;

  typedef struct packed {
    logic       cap0;
    logic       cap1;
    logic       cap2;
    logic       load_mul;
    logic       mul_step;
    logic       write_dst;
    op_t        op;
    logic       div_load;
    logic       div_step;
    logic       div_rnd;
    logic       div_sat;
    logic [1:0] idx;
    logic       emit;
    logic       degen;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic s_zero;
  } sts_t;

  function automatic op_t mk_op(opnd_t a, opnd_t b, logic sub, logic lng, logic last,
                                opnd_t dst);
    op_t o;
    o.a    = a;
    o.b    = b;
    o.sub  = sub;
    o.lng  = lng;
    o.last = last;
    o.dst  = dst;
    return o;
  endfunction

  // Nrm = U x V, W1 = V x Nrm, W2 = Nrm x U, S = Nrm.Nrm, M = dD2*W1 + dD3*W2
  function automatic op_t op_of(logic [STEP_W-1:0] step);
    op_t o;
    o = mk_op(OP_U0, OP_U0, 1'b0, 1'b0, 1'b0, OP_U0);
    unique case (step)
      5'd0:  o = mk_op(OP_U1,  OP_V2,  1'b0, 1'b0, 1'b0, OP_N0);
      5'd1:  o = mk_op(OP_U2,  OP_V1,  1'b1, 1'b0, 1'b1, OP_N0);
      5'd2:  o = mk_op(OP_U2,  OP_V0,  1'b0, 1'b0, 1'b0, OP_N1);
      5'd3:  o = mk_op(OP_U0,  OP_V2,  1'b1, 1'b0, 1'b1, OP_N1);
      5'd4:  o = mk_op(OP_U0,  OP_V1,  1'b0, 1'b0, 1'b0, OP_N2);
      5'd5:  o = mk_op(OP_U1,  OP_V0,  1'b1, 1'b0, 1'b1, OP_N2);
      5'd6:  o = mk_op(OP_N2,  OP_V1,  1'b0, 1'b0, 1'b0, OP_W10);
      5'd7:  o = mk_op(OP_N1,  OP_V2,  1'b1, 1'b0, 1'b1, OP_W10);
      5'd8:  o = mk_op(OP_N0,  OP_V2,  1'b0, 1'b0, 1'b0, OP_W11);
      5'd9:  o = mk_op(OP_N2,  OP_V0,  1'b1, 1'b0, 1'b1, OP_W11);
      5'd10: o = mk_op(OP_N1,  OP_V0,  1'b0, 1'b0, 1'b0, OP_W12);
      5'd11: o = mk_op(OP_N0,  OP_V1,  1'b1, 1'b0, 1'b1, OP_W12);
      5'd12: o = mk_op(OP_N1,  OP_U2,  1'b0, 1'b0, 1'b0, OP_W20);
      5'd13: o = mk_op(OP_N2,  OP_U1,  1'b1, 1'b0, 1'b1, OP_W20);
      5'd14: o = mk_op(OP_N2,  OP_U0,  1'b0, 1'b0, 1'b0, OP_W21);
      5'd15: o = mk_op(OP_N0,  OP_U2,  1'b1, 1'b0, 1'b1, OP_W21);
      5'd16: o = mk_op(OP_N0,  OP_U1,  1'b0, 1'b0, 1'b0, OP_W22);
      5'd17: o = mk_op(OP_N1,  OP_U0,  1'b1, 1'b0, 1'b1, OP_W22);
      5'd18: o = mk_op(OP_N0,  OP_N0,  1'b0, 1'b1, 1'b0, OP_S);
      5'd19: o = mk_op(OP_N1,  OP_N1,  1'b0, 1'b1, 1'b0, OP_S);
      5'd20: o = mk_op(OP_N2,  OP_N2,  1'b0, 1'b1, 1'b1, OP_S);
      5'd21: o = mk_op(OP_W10, OP_D20, 1'b0, 1'b0, 1'b0, OP_M0);
      5'd22: o = mk_op(OP_W20, OP_D30, 1'b0, 1'b0, 1'b1, OP_M0);
      5'd23: o = mk_op(OP_W11, OP_D21, 1'b0, 1'b0, 1'b0, OP_M1);
      5'd24: o = mk_op(OP_W21, OP_D31, 1'b0, 1'b0, 1'b1, OP_M1);
      5'd25: o = mk_op(OP_W12, OP_D22, 1'b0, 1'b0, 1'b0, OP_M2);
      5'd26: o = mk_op(OP_W22, OP_D32, 1'b0, 1'b0, 1'b1, OP_M2);
      default: o = mk_op(OP_U0, OP_U0, 1'b0, 1'b0, 1'b0, OP_U0);
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tdg_ctrl.sv =====
// Sequencer for the triangle gradient: corner bookkeeping, the product
// schedule and the three divisions. Depends on tdg_pkg.
`default_nettype none

module tdg_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [1:0]    in_corner,
  input  wire tdg_pkg::sts_t sts,
  output tdg_pkg::cmd_t      cmd,
  output logic               busy
);

  tdg_pkg::state_t state_r, state_nxt;
  logic [tdg_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [1:0] loaded_r, loaded_nxt;
  logic cap0, cap1, cap2;

  assign busy = (state_r != tdg_pkg::ST_IDLE);
  assign cap0 = start && !busy && (in_corner == tdg_pkg::CORNER_0);
  assign cap1 = start && !busy && (in_corner == tdg_pkg::CORNER_1) &&
                (loaded_r == tdg_pkg::CORNER_1);
  assign cap2 = start && !busy && (in_corner == tdg_pkg::CORNER_2) &&
                (loaded_r == tdg_pkg::CORNER_2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tdg_pkg::ST_IDLE;
      step_r   <= '0;
      idx_r    <= '0;
      loaded_r <= '0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      idx_r    <= idx_nxt;
      loaded_r <= loaded_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    idx_nxt    = idx_r;
    loaded_nxt = loaded_r;
    unique case (state_r)
      tdg_pkg::ST_IDLE: begin
        if (cap0) begin
          loaded_nxt = 2'd1;
        end else if (cap1) begin
          loaded_nxt = 2'd2;
        end else if (cap2) begin
          loaded_nxt = 2'd0;
          step_nxt   = '0;
          state_nxt  = tdg_pkg::ST_MLOAD;
        end
      end
      tdg_pkg::ST_MLOAD: state_nxt = tdg_pkg::ST_MSTEP;
      tdg_pkg::ST_MSTEP: begin
        if (sts.cnt_last) begin
          if (step_r == tdg_pkg::STEP_W'(tdg_pkg::NUM_OPS - 1)) begin
            state_nxt = tdg_pkg::ST_CHECK;
          end else begin
            step_nxt  = step_r + 1'b1;
            state_nxt = tdg_pkg::ST_MLOAD;
          end
        end
      end
      tdg_pkg::ST_CHECK: begin
        idx_nxt   = '0;
        state_nxt = sts.s_zero ? tdg_pkg::ST_EMIT : tdg_pkg::ST_DLOAD;
      end
      tdg_pkg::ST_DLOAD: state_nxt = tdg_pkg::ST_DSTEP;
      tdg_pkg::ST_DSTEP: begin
        if (sts.cnt_last) state_nxt = tdg_pkg::ST_DRND;
      end
      tdg_pkg::ST_DRND: state_nxt = tdg_pkg::ST_DSAT;
      tdg_pkg::ST_DSAT: begin
        if (idx_r == tdg_pkg::LAST_IDX) begin
          state_nxt = tdg_pkg::ST_EMIT;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = tdg_pkg::ST_DLOAD;
        end
      end
      tdg_pkg::ST_EMIT: state_nxt = tdg_pkg::ST_IDLE;
      default: state_nxt = tdg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.op    = tdg_pkg::op_of(step_r);
    cmd.idx   = idx_r;
    unique case (state_r)
      tdg_pkg::ST_IDLE: begin
        cmd.cap0 = cap0;
        cmd.cap1 = cap1;
        cmd.cap2 = cap2;
      end
      tdg_pkg::ST_MLOAD: cmd.load_mul = 1'b1;
      tdg_pkg::ST_MSTEP: begin
        cmd.mul_step  = 1'b1;
        cmd.write_dst = cmd.op.last && sts.cnt_last;
      end
      tdg_pkg::ST_CHECK: ;
      tdg_pkg::ST_DLOAD: cmd.div_load = 1'b1;
      tdg_pkg::ST_DSTEP: cmd.div_step = 1'b1;
      tdg_pkg::ST_DRND:  cmd.div_rnd  = 1'b1;
      tdg_pkg::ST_DSAT:  cmd.div_sat  = 1'b1;
      tdg_pkg::ST_EMIT: begin
        cmd.emit  = 1'b1;
        cmd.degen = sts.s_zero;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tdg_dpath.sv =====
// Datapath of the triangle gradient: corner differences, a shift-add
// multiply-accumulate, a restoring divider and the output registers.
// Depends on tdg_pkg.
`default_nettype none

module tdg_dpath #(
  parameter int CW = tdg_pkg::COORD_WIDTH,
  parameter int OW = tdg_pkg::OUT_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tdg_pkg::cmd_t        cmd,
  output tdg_pkg::sts_t             sts,
  input  wire logic signed [CW-1:0] pos_x,
  input  wire logic signed [CW-1:0] pos_y,
  input  wire logic signed [CW-1:0] pos_z,
  input  wire logic signed [CW-1:0] disp_x,
  input  wire logic signed [CW-1:0] disp_y,
  input  wire logic signed [CW-1:0] disp_z,
  output logic                      out_valid,
  output logic signed [OW-1:0]      grad_xx,
  output logic signed [OW-1:0]      grad_yy,
  output logic signed [OW-1:0]      grad_zz,
  output logic                      degenerate,
  output logic                      saturated
);

  localparam int DW   = CW + 1;
  localparam int MB   = 2 * CW + 3;
  localparam int WW   = 4 * CW + 32;
  localparam int CNTW = $clog2(WW + 1);

  logic signed [CW-1:0] pos [3];
  logic signed [CW-1:0] disp [3];

  logic signed [CW-1:0] p1_r [3];
  logic signed [CW-1:0] d1_r [3];
  logic signed [DW-1:0] u_r [3];
  logic signed [DW-1:0] v_r [3];
  logic signed [DW-1:0] e2_r [3];
  logic signed [DW-1:0] e3_r [3];
  logic signed [WW-1:0] n_r [3];
  logic signed [WW-1:0] w1_r [3];
  logic signed [WW-1:0] w2_r [3];
  logic signed [WW-1:0] m_r [3];
  logic [WW-1:0]        s_r;

  logic signed [WW-1:0] acc_r, mcand_r;
  logic [MB-1:0]        mplier_r;
  logic [CNTW-1:0]      cnt_r;

  logic [WW-1:0] dvd_r, q_r;
  logic [WW:0]   rem_r;
  logic          neg_r;

  logic signed [OW-1:0] g_r [3];
  logic                 degen_r, sat_r, valid_r;

  logic signed [WW-1:0] opa, opb, acc_sum, num_sel, mag;
  logic                 neg_term;
  logic [WW:0]          r_sh, s_ext;
  logic                 ge;
  logic [WW-1:0]        lim, qc, res;
  logic                 over;

  assign pos  = '{pos_x, pos_y, pos_z};
  assign disp = '{disp_x, disp_y, disp_z};

  always_comb begin
    unique case (cmd.op.a)
      tdg_pkg::OP_N0:  opa = n_r[0];
      tdg_pkg::OP_N1:  opa = n_r[1];
      tdg_pkg::OP_N2:  opa = n_r[2];
      tdg_pkg::OP_U0:  opa = WW'(u_r[0]);
      tdg_pkg::OP_U1:  opa = WW'(u_r[1]);
      tdg_pkg::OP_U2:  opa = WW'(u_r[2]);
      tdg_pkg::OP_W10: opa = w1_r[0];
      tdg_pkg::OP_W11: opa = w1_r[1];
      tdg_pkg::OP_W12: opa = w1_r[2];
      tdg_pkg::OP_W20: opa = w2_r[0];
      tdg_pkg::OP_W21: opa = w2_r[1];
      tdg_pkg::OP_W22: opa = w2_r[2];
      default:         opa = '0;
    endcase
    unique case (cmd.op.b)
      tdg_pkg::OP_U0:  opb = WW'(u_r[0]);
      tdg_pkg::OP_U1:  opb = WW'(u_r[1]);
      tdg_pkg::OP_U2:  opb = WW'(u_r[2]);
      tdg_pkg::OP_V0:  opb = WW'(v_r[0]);
      tdg_pkg::OP_V1:  opb = WW'(v_r[1]);
      tdg_pkg::OP_V2:  opb = WW'(v_r[2]);
      tdg_pkg::OP_N0:  opb = n_r[0];
      tdg_pkg::OP_N1:  opb = n_r[1];
      tdg_pkg::OP_N2:  opb = n_r[2];
      tdg_pkg::OP_D20: opb = WW'(e2_r[0]);
      tdg_pkg::OP_D21: opb = WW'(e2_r[1]);
      tdg_pkg::OP_D22: opb = WW'(e2_r[2]);
      tdg_pkg::OP_D30: opb = WW'(e3_r[0]);
      tdg_pkg::OP_D31: opb = WW'(e3_r[1]);
      tdg_pkg::OP_D32: opb = WW'(e3_r[2]);
      default:         opb = '0;
    endcase
    unique case (cmd.idx)
      2'd0:    num_sel = m_r[0];
      2'd1:    num_sel = m_r[1];
      default: num_sel = m_r[2];
    endcase
  end

  // the multiplier's top bit weighs negative: subtract on the last step
  assign neg_term = cmd.op.sub ^ (cnt_r == CNTW'(1));
  assign acc_sum  = !mplier_r[0] ? acc_r :
                    neg_term ? acc_r - mcand_r : acc_r + mcand_r;

  assign mag   = num_sel[WW-1] ? -num_sel : num_sel;
  assign r_sh  = {rem_r[WW-1:0], dvd_r[WW-1]};
  assign s_ext = {1'b0, s_r};
  assign ge    = (r_sh >= s_ext);

  assign lim  = (WW'(1) << (OW - 1)) - (neg_r ? WW'(0) : WW'(1));
  assign over = (q_r > lim);
  assign qc   = over ? lim : q_r;
  assign res  = neg_r ? -qc : qc;

  assign sts.cnt_last = (cnt_r == CNTW'(1));
  assign sts.s_zero   = (s_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd.cap0) begin
        p1_r[k] <= pos[k];
        d1_r[k] <= disp[k];
      end
      if (cmd.cap1) begin
        u_r[k]  <= DW'(pos[k]) - DW'(p1_r[k]);
        e2_r[k] <= DW'(disp[k]) - DW'(d1_r[k]);
      end
      if (cmd.cap2) begin
        v_r[k]  <= DW'(pos[k]) - DW'(p1_r[k]);
        e3_r[k] <= DW'(disp[k]) - DW'(d1_r[k]);
      end
    end
    if (cmd.cap2) begin
      acc_r   <= '0;
      sat_r   <= 1'b0;
      degen_r <= 1'b0;
    end

    if (cmd.load_mul) begin
      mcand_r  <= opa;
      mplier_r <= opb[MB-1:0];
      cnt_r    <= cmd.op.lng ? CNTW'(MB) : CNTW'(DW);
    end

    if (cmd.mul_step) begin
      acc_r    <= cmd.write_dst ? '0 : acc_sum;
      mcand_r  <= mcand_r <<< 1;
      mplier_r <= mplier_r >> 1;
      cnt_r    <= cnt_r - 1'b1;
      if (cmd.write_dst) begin
        unique case (cmd.op.dst)
          tdg_pkg::OP_N0:  n_r[0]  <= acc_sum;
          tdg_pkg::OP_N1:  n_r[1]  <= acc_sum;
          tdg_pkg::OP_N2:  n_r[2]  <= acc_sum;
          tdg_pkg::OP_W10: w1_r[0] <= acc_sum;
          tdg_pkg::OP_W11: w1_r[1] <= acc_sum;
          tdg_pkg::OP_W12: w1_r[2] <= acc_sum;
          tdg_pkg::OP_W20: w2_r[0] <= acc_sum;
          tdg_pkg::OP_W21: w2_r[1] <= acc_sum;
          tdg_pkg::OP_W22: w2_r[2] <= acc_sum;
          tdg_pkg::OP_S:   s_r     <= acc_sum;
          tdg_pkg::OP_M0:  m_r[0]  <= acc_sum;
          tdg_pkg::OP_M1:  m_r[1]  <= acc_sum;
          tdg_pkg::OP_M2:  m_r[2]  <= acc_sum;
          default: ;
        endcase
      end
    end

    if (cmd.div_load) begin
      neg_r <= num_sel[WW-1];
      dvd_r <= mag << tdg_pkg::GRAD_FRAC;
      rem_r <= '0;
      q_r   <= '0;
      cnt_r <= CNTW'(WW);
    end

    if (cmd.div_step) begin
      rem_r <= ge ? r_sh - s_ext : r_sh;
      q_r   <= {q_r[WW-2:0], ge};
      dvd_r <= dvd_r << 1;
      cnt_r <= cnt_r - 1'b1;
    end

    // round half away from zero on the magnitude
    if (cmd.div_rnd) begin
      if ({rem_r, 1'b0} >= {1'b0, s_ext}) q_r <= q_r + 1'b1;
    end

    if (cmd.div_sat) begin
      unique case (cmd.idx)
        2'd0:    g_r[0] <= res[OW-1:0];
        2'd1:    g_r[1] <= res[OW-1:0];
        default: g_r[2] <= res[OW-1:0];
      endcase
      sat_r <= sat_r | over;
    end

    if (cmd.emit && cmd.degen) begin
      g_r     <= '{'0, '0, '0};
      degen_r <= 1'b1;
      sat_r   <= 1'b0;
    end
  end

  assign out_valid  = valid_r;
  assign grad_xx    = g_r[0];
  assign grad_yy    = g_r[1];
  assign grad_zz    = g_r[2];
  assign degenerate = degen_r;
  assign saturated  = sat_r;

endmodule

`default_nettype wire

// ===== hw/rtl/triangle_displacement_gradient.sv =====
// Top level of the triangle displacement gradient block: ties the sequencer
// to the datapath. Depends on tdg_pkg, tdg_ctrl and tdg_dpath.
//
// Feed corners 0, 1 and 2 of a triangle in turn with start; an item is taken
// when start is high and busy is low. Corners 0 and 1 are captured without
// raising busy. A corner 2 that follows in sequence raises busy while the
// block works out the gradient diagonal through one shift-add multiplier and
// one restoring divider: 24 products, 3 longer ones for the squared normal,
// then, unless the normal is zero, 3 divisions. The result then appears for a
// single cycle with out_valid; the receiver cannot stall and must take it
// then. Corners out of sequence are taken and dropped without a result.
`default_nettype none

module triangle_displacement_gradient #(
  parameter int CW = tdg_pkg::COORD_WIDTH,
  parameter int OW = tdg_pkg::OUT_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           in_corner,
  input  wire logic signed [CW-1:0] in_pos_x,
  input  wire logic signed [CW-1:0] in_pos_y,
  input  wire logic signed [CW-1:0] in_pos_z,
  input  wire logic signed [CW-1:0] in_disp_x,
  input  wire logic signed [CW-1:0] in_disp_y,
  input  wire logic signed [CW-1:0] in_disp_z,
  output logic                      out_valid,
  output logic signed [OW-1:0]      out_grad_xx,
  output logic signed [OW-1:0]      out_grad_yy,
  output logic signed [OW-1:0]      out_grad_zz,
  output logic                      out_degenerate,
  output logic                      out_saturated
);

  tdg_pkg::cmd_t cmd;
  tdg_pkg::sts_t sts;

  tdg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_corner (in_corner),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  tdg_dpath #(.CW(CW), .OW(OW)) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .pos_x      (in_pos_x),
    .pos_y      (in_pos_y),
    .pos_z      (in_pos_z),
    .disp_x     (in_disp_x),
    .disp_y     (in_disp_y),
    .disp_z     (in_disp_z),
    .out_valid  (out_valid),
    .grad_xx    (out_grad_xx),
    .grad_yy    (out_grad_yy),
    .grad_zz    (out_grad_zz),
    .degenerate (out_degenerate),
    .saturated  (out_saturated)
  );

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) && !busy)
    else $error("result strobe without a finished computation");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_grad_xx == '0) && (out_grad_yy == '0) && (out_grad_zz == '0) &&
      !out_saturated)
    else $error("degenerate result carries nonzero data");

  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.mul_step && cmd.div_step) && !(cmd.emit && !busy))
    else $error("conflicting datapath commands");

endmodule

`default_nettype wire
